[sv/pbpc_pkg.sv]
// ----------------------------------------------------------------------------
// pbpc_pkg
// Types and codes shared by the panic button press classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpc_pkg;

  // Classifier states
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_WINDOW   = 2'd3
  } mode_t;

  // Event codes reported with each result
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BOUNCE  = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_CANCEL  = 3'd4,
    EV_ARMED   = 3'd5,
    EV_EXPIRED = 3'd6
  } event_t;

  // Request commands
  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TIME    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CANCEL_WINDOW_TIME = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_TIME_RST      = 16'd50;
  localparam logic [31:0] LONG_PRESS_TIME_RST    = 32'd3000;
  localparam logic [31:0] CANCEL_WINDOW_TIME_RST = 32'd5000;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [31:0] long_press_time;
    logic [31:0] cancel_window_time;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        pressed;
  } in_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [1:0] state_before;
    logic [1:0] state_after;
    logic       state_changed;
  } out_t;

endpackage

`default_nettype wire

[sv/panic_button_press_classifier.sv]
// ----------------------------------------------------------------------------
// panic_button_press_classifier
// Debounced short/long press detector with a cancel window.
// ----------------------------------------------------------------------------
// Each request carries a command, a millisecond timestamp and the raw button
// level, and gives exactly one result: the event, the state before and after
// and whether a transition happened. The block takes one request per clock
// sustained while the output is not stalled; a request is held in an input
// register, classified in one pass against the stored state, and its result
// loaded into the output register once that register is free. The state
// update of one request completes in the same cycle as its result is
// registered, which is what sets the one-per-clock figure. Configuration is
// written through a plain write port and takes effect on the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module panic_button_press_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire pbpc_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output pbpc_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [pbpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pbpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pbpc_pkg::cfg_t cfg;
  pbpc_pkg::in_t  s1_item;
  pbpc_pkg::out_t result;
  logic           s1_valid;
  logic           s2_free;
  logic           s1_fire;

  pbpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbpc_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  // Handshake: advance when the result register is empty or being taken
  assign s2_free  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[sv/pbpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pbpc_cfg_regs
// Configuration registers: debounce, long press and cancel window times.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [pbpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pbpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output pbpc_pkg::cfg_t                            cfg
);

  pbpc_pkg::cfg_t regs;

  // Write the addressed register; drop writes to unlisted indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_time      <= pbpc_pkg::DEBOUNCE_TIME_RST;
      regs.long_press_time    <= pbpc_pkg::LONG_PRESS_TIME_RST;
      regs.cancel_window_time <= pbpc_pkg::CANCEL_WINDOW_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbpc_pkg::CFG_DEBOUNCE_TIME:      regs.debounce_time      <= cfg_data[15:0];
        pbpc_pkg::CFG_LONG_PRESS_TIME:    regs.long_press_time    <= cfg_data[31:0];
        pbpc_pkg::CFG_CANCEL_WINDOW_TIME: regs.cancel_window_time <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[sv/pbpc_fsm.sv]
// ----------------------------------------------------------------------------
// pbpc_fsm
// Press classifier state and single-pass step logic for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_fsm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire pbpc_pkg::in_t  item,
  input  wire pbpc_pkg::cfg_t cfg,
  output pbpc_pkg::out_t      result
);

  pbpc_pkg::mode_t mode, mode_next;
  logic [31:0] debounce_start, debounce_start_next;
  logic [31:0] press_start, press_start_next;
  logic [31:0] window_start, window_start_next;
  logic [31:0] level_change_time, level_change_time_next;
  logic        last_level, last_level_next;
  logic        idle_previous_level, idle_previous_level_next;
  logic        long_alert_sent, long_alert_sent_next;
  logic        cancel_armed_flag, cancel_armed_flag_next;

  logic [31:0] now;
  logic        lvl;
  logic [31:0] change_time_eff;
  logic [31:0] el_debounce;
  logic [31:0] el_press;
  logic [31:0] el_window;
  logic [31:0] el_level;
  logic [31:0] debounce_ext;
  logic        stable;
  logic        done;
  pbpc_pkg::event_t ev;
  logic        changed;

  assign now          = item.now_ms;
  assign lvl          = item.pressed;
  assign debounce_ext = {16'd0, cfg.debounce_time};

  // Level change time as seen after this sample
  assign change_time_eff = (lvl != last_level) ? now : level_change_time;

  // Modular elapsed times
  assign el_debounce = now - debounce_start;
  assign el_press    = now - press_start;
  assign el_window   = now - window_start;
  assign el_level    = now - change_time_eff;
  assign stable      = (el_level >= debounce_ext);

  // Next state and event for the current request
  always_comb begin
    mode_next                = mode;
    debounce_start_next      = debounce_start;
    press_start_next         = press_start;
    window_start_next        = window_start;
    level_change_time_next   = level_change_time;
    last_level_next          = last_level;
    idle_previous_level_next = idle_previous_level;
    long_alert_sent_next     = long_alert_sent;
    cancel_armed_flag_next   = cancel_armed_flag;
    ev                       = pbpc_pkg::EV_NONE;
    changed                  = 1'b0;
    done                     = 1'b0;

    if (item.command == pbpc_pkg::CMD_START) begin
      mode_next                = pbpc_pkg::MODE_IDLE;
      debounce_start_next      = now;
      press_start_next         = now;
      window_start_next        = now;
      level_change_time_next   = now;
      last_level_next          = lvl;
      idle_previous_level_next = lvl;
      long_alert_sent_next     = 1'b0;
      cancel_armed_flag_next   = 1'b0;
    end else begin
      unique case (mode)
        pbpc_pkg::MODE_IDLE: begin
          // Leave idle only on a released-to-pressed edge
          idle_previous_level_next = lvl;
          if (lvl && !idle_previous_level) begin
            debounce_start_next = now;
            mode_next           = pbpc_pkg::MODE_DEBOUNCE;
            changed             = 1'b1;
          end
        end
        pbpc_pkg::MODE_DEBOUNCE: begin
          if (!lvl) begin
            ev                       = pbpc_pkg::EV_BOUNCE;
            idle_previous_level_next = lvl;
            mode_next                = pbpc_pkg::MODE_IDLE;
            changed                  = 1'b1;
          end else if (el_debounce >= debounce_ext) begin
            press_start_next       = now;
            long_alert_sent_next   = 1'b0;
            last_level_next        = 1'b1;
            level_change_time_next = now;
            mode_next              = pbpc_pkg::MODE_PRESSED;
            changed                = 1'b1;
          end
        end
        pbpc_pkg::MODE_PRESSED: begin
          if (!long_alert_sent && lvl && (el_press >= cfg.long_press_time)) begin
            long_alert_sent_next   = 1'b1;
            window_start_next      = now;
            cancel_armed_flag_next = 1'b0;
            last_level_next        = 1'b1;
            level_change_time_next = now;
            mode_next              = pbpc_pkg::MODE_WINDOW;
            ev                     = pbpc_pkg::EV_LONG;
            changed                = 1'b1;
          end else begin
            last_level_next        = lvl;
            level_change_time_next = change_time_eff;
            if (!lvl && stable) begin
              window_start_next      = now;
              cancel_armed_flag_next = 1'b1;
              last_level_next        = 1'b0;
              level_change_time_next = now;
              mode_next              = pbpc_pkg::MODE_WINDOW;
              ev                     = pbpc_pkg::EV_SHORT;
              changed                = 1'b1;
            end
          end
        end
        pbpc_pkg::MODE_WINDOW: begin
          last_level_next        = lvl;
          level_change_time_next = change_time_eff;
          // Stable release arms cancelling, stable press then cancels
          if (!cancel_armed_flag) begin
            if (!lvl && stable) begin
              cancel_armed_flag_next = 1'b1;
              ev                     = pbpc_pkg::EV_ARMED;
              done                   = 1'b1;
            end
          end else if (lvl && stable) begin
            ev                       = pbpc_pkg::EV_CANCEL;
            idle_previous_level_next = lvl;
            mode_next                = pbpc_pkg::MODE_IDLE;
            changed                  = 1'b1;
            done                     = 1'b1;
          end
          // Expire the window when nothing else happened
          if (!done && (el_window >= cfg.cancel_window_time)) begin
            ev                       = pbpc_pkg::EV_EXPIRED;
            idle_previous_level_next = lvl;
            mode_next                = pbpc_pkg::MODE_IDLE;
            changed                  = 1'b1;
          end
        end
      endcase
    end
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= pbpc_pkg::MODE_IDLE;
      debounce_start      <= 32'd0;
      press_start         <= 32'd0;
      window_start        <= 32'd0;
      level_change_time   <= 32'd0;
      last_level          <= 1'b1;
      idle_previous_level <= 1'b1;
      long_alert_sent     <= 1'b0;
      cancel_armed_flag   <= 1'b0;
    end else if (step) begin
      mode                <= mode_next;
      debounce_start      <= debounce_start_next;
      press_start         <= press_start_next;
      window_start        <= window_start_next;
      level_change_time   <= level_change_time_next;
      last_level          <= last_level_next;
      idle_previous_level <= idle_previous_level_next;
      long_alert_sent     <= long_alert_sent_next;
      cancel_armed_flag   <= cancel_armed_flag_next;
    end
  end

  // Pack event, state before, state after and transition flag
  assign result = {ev, mode, mode_next, changed};

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the panic button press classifier.
// ----------------------------------------------------------------------------
// Requests carrying a command, a timestamp and a button level are driven
// through the valid/ready input. A tracker that keeps its own copy of the
// classifier state and of the registers predicts one result per accepted
// request. Every result taken from the output is checked field by field
// against the oldest prediction. A directed press sequence comes first. Then
// randomised press and release runs follow under several register settings
// and several idling patterns on both sides.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes there must be ignored
  localparam logic [pbpc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;

  // --------------------------------------------------------------------------
  // Press tracker: mirrors the classifier and holds the events still owed
  // --------------------------------------------------------------------------
  class press_event_tracker;
    logic [15:0] debounce_limit;
    logic [31:0] long_press_ms;
    logic [31:0] window_ms;

    pbpc_pkg::mode_t mode;
    logic [31:0] debounce_t0;
    logic [31:0] press_t0;
    logic [31:0] window_t0;
    logic [31:0] level_t0;
    logic        last_lvl;
    logic        idle_prev_lvl;
    logic        long_sent;
    logic        armed;

    pbpc_pkg::out_t pending_events[$];
    int unsigned    event_mismatches;

    function new();
      debounce_limit   = pbpc_pkg::DEBOUNCE_TIME_RST;
      long_press_ms    = pbpc_pkg::LONG_PRESS_TIME_RST;
      window_ms        = pbpc_pkg::CANCEL_WINDOW_TIME_RST;
      mode             = pbpc_pkg::MODE_IDLE;
      debounce_t0      = '0;
      press_t0         = '0;
      window_t0        = '0;
      level_t0         = '0;
      last_lvl         = 1'b1;
      idle_prev_lvl    = 1'b1;
      long_sent        = 1'b0;
      armed            = 1'b0;
      event_mismatches = 0;
    endfunction

    function void write_register(logic [pbpc_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [pbpc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pbpc_pkg::CFG_DEBOUNCE_TIME:      debounce_limit = data[15:0];
        pbpc_pkg::CFG_LONG_PRESS_TIME:    long_press_ms  = data;
        pbpc_pkg::CFG_CANCEL_WINDOW_TIME: window_ms      = data;
        default: ;
      endcase
    endfunction

    // Modular millisecond difference
    function logic [31:0] since_ms(logic [31:0] now, logic [31:0] start);
      return now - start;
    endfunction

    // Advance the mirrored state by one request and queue its event
    function void predict_event(pbpc_pkg::in_t req);
      pbpc_pkg::out_t   exp;
      pbpc_pkg::event_t ev;
      pbpc_pkg::mode_t  prior;
      logic [31:0] now;
      logic        lvl;
      logic        chg;
      logic        stable;
      logic        done;

      now   = req.now_ms;
      lvl   = req.pressed;
      prior = mode;
      ev    = pbpc_pkg::EV_NONE;
      chg   = 1'b0;
      done  = 1'b0;

      if (req.command == pbpc_pkg::CMD_START) begin
        mode          = pbpc_pkg::MODE_IDLE;
        debounce_t0   = now;
        press_t0      = now;
        window_t0     = now;
        level_t0      = now;
        last_lvl      = lvl;
        idle_prev_lvl = lvl;
        long_sent     = 1'b0;
        armed         = 1'b0;
      end else begin
        case (mode)
          pbpc_pkg::MODE_IDLE: begin
            // only a released-to-pressed edge leaves idle
            if (lvl && !idle_prev_lvl) begin
              debounce_t0 = now;
              mode        = pbpc_pkg::MODE_DEBOUNCE;
              chg         = 1'b1;
            end
            idle_prev_lvl = lvl;
          end
          pbpc_pkg::MODE_DEBOUNCE: begin
            if (!lvl) begin
              ev            = pbpc_pkg::EV_BOUNCE;
              idle_prev_lvl = lvl;
              mode          = pbpc_pkg::MODE_IDLE;
              chg           = 1'b1;
            end else if (since_ms(now, debounce_t0) >= {16'd0, debounce_limit}) begin
              press_t0  = now;
              long_sent = 1'b0;
              last_lvl  = 1'b1;
              level_t0  = now;
              mode      = pbpc_pkg::MODE_PRESSED;
              chg       = 1'b1;
            end
          end
          pbpc_pkg::MODE_PRESSED: begin
            // long alert only while the button is still held
            if (!long_sent && lvl && since_ms(now, press_t0) >= long_press_ms) begin
              long_sent = 1'b1;
              window_t0 = now;
              armed     = 1'b0;
              last_lvl  = 1'b1;
              level_t0  = now;
              mode      = pbpc_pkg::MODE_WINDOW;
              ev        = pbpc_pkg::EV_LONG;
              chg       = 1'b1;
            end else begin
              if (lvl != last_lvl) begin
                last_lvl = lvl;
                level_t0 = now;
              end
              if (!lvl && since_ms(now, level_t0) >= {16'd0, debounce_limit}) begin
                window_t0 = now;
                armed     = 1'b1;
                last_lvl  = 1'b0;
                level_t0  = now;
                mode      = pbpc_pkg::MODE_WINDOW;
                ev        = pbpc_pkg::EV_SHORT;
                chg       = 1'b1;
              end
            end
          end
          default: begin
            if (lvl != last_lvl) begin
              last_lvl = lvl;
              level_t0 = now;
            end
            stable = since_ms(now, level_t0) >= {16'd0, debounce_limit};
            if (!armed) begin
              // arming skips the expiry test on the same request
              if (!lvl && stable) begin
                armed = 1'b1;
                ev    = pbpc_pkg::EV_ARMED;
                done  = 1'b1;
              end
            end else if (lvl && stable) begin
              ev            = pbpc_pkg::EV_CANCEL;
              idle_prev_lvl = lvl;
              mode          = pbpc_pkg::MODE_IDLE;
              chg           = 1'b1;
              done          = 1'b1;
            end
            if (!done && since_ms(now, window_t0) >= window_ms) begin
              ev            = pbpc_pkg::EV_EXPIRED;
              idle_prev_lvl = lvl;
              mode          = pbpc_pkg::MODE_IDLE;
              chg           = 1'b1;
            end
          end
        endcase
      end

      exp.event_code    = ev;
      exp.state_before  = prior;
      exp.state_after   = mode;
      exp.state_changed = chg;
      pending_events.push_back(exp);
    endfunction

    // Compare one delivered result with the oldest owed event
    function void check_event(pbpc_pkg::out_t got);
      pbpc_pkg::out_t exp;
      if (pending_events.size() == 0) begin
        event_mismatches++;
        if (event_mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: event %0d state %0d->%0d chg %0d",
                   $realtime, got.event_code, got.state_before, got.state_after,
                   got.state_changed);
        return;
      end
      exp = pending_events.pop_front();
      if (got !== exp) begin
        event_mismatches++;
        if (event_mismatches <= MAX_REPORTS) begin
          $write("%0t: mismatch: expected event %0d state %0d->%0d chg %0d,",
                 $realtime, exp.event_code, exp.state_before, exp.state_after,
                 exp.state_changed);
          $display(" got event %0d state %0d->%0d chg %0d",
                   got.event_code, got.state_before, got.state_after,
                   got.state_changed);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  pbpc_pkg::in_t                    in_data;
  logic                             out_valid;
  logic                             out_ready;
  pbpc_pkg::out_t                   out_data;
  logic                             cfg_we;
  logic [pbpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pbpc_pkg::CFG_DATA_W-1:0]  cfg_data;

  press_event_tracker tracker;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_off_cycles;

  panic_button_press_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drive out_ready: random stalls, plus long hold-offs on demand
  initial begin : receiver
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        n               = hold_off_cycles;
        hold_off_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample results half a cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_event(out_data);
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  function automatic pbpc_pkg::in_t make_req(pbpc_pkg::cmd_t cmd, logic [31:0] now_ms,
                                             logic lvl);
    pbpc_pkg::in_t req;
    req.command = cmd;
    req.now_ms  = now_ms;
    req.pressed = lvl;
    return req;
  endfunction

  // Offer one request, hold it until taken; valid is left high afterwards
  task automatic send_request(input pbpc_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    tracker.predict_event(req);
  endtask

  // Wait until every owed result has come back
  task automatic wait_idle();
    while (tracker.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register; the caller drops the write enable afterwards
  task automatic cfg_write(input logic [pbpc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pbpc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_register(idx, data);
  endtask

  task automatic configure(input logic [15:0] deb, input logic [31:0] long_ms,
                           input logic [31:0] win_ms);
    cfg_write(CFG_UNUSED_INDEX, $urandom());
    cfg_write(pbpc_pkg::CFG_DEBOUNCE_TIME, {16'($urandom()), deb});
    cfg_write(pbpc_pkg::CFG_LONG_PRESS_TIME, long_ms);
    cfg_write(pbpc_pkg::CFG_CANCEL_WINDOW_TIME, win_ms);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random press/release runs with bounces, time jumps and restarts
  task automatic run_random(input int unsigned count, input int unsigned delta_max,
                            input int unsigned flip_pct, input int unsigned hold_off);
    logic [31:0]    now_ms;
    logic           held;
    logic           lvl;
    pbpc_pkg::cmd_t cmd;
    now_ms = $urandom();
    held   = 1'($urandom_range(1));
    for (int unsigned i = 0; i < count; i++) begin
      // stall the output mid-phase while requests keep coming
      if (hold_off != 0 && i == count / 2)
        hold_off_cycles = hold_off;
      case ($urandom_range(19))
        0:       ;
        1:       now_ms = now_ms + $urandom();
        2, 3:    now_ms = now_ms + $urandom_range(3);
        default: now_ms = now_ms + $urandom_range(delta_max);
      endcase
      if ($urandom_range(99) < flip_pct)
        held = ~held;
      lvl = held;
      if ($urandom_range(99) < 5)
        lvl = ~lvl;
      cmd = ($urandom_range(99) < 3) ? pbpc_pkg::CMD_START : pbpc_pkg::CMD_UPDATE;
      send_request(make_req(cmd, now_ms, lvl));
    end
    in_valid <= 1'b0;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker         = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values, every event and the corner cases
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd0, 1'b1));     // held at reset: no edge
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd10, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd20, 1'b1));    // enter debounce
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd30, 1'b0));    // bounce
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd40, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd100, 1'b1));   // pressed
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd200, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd260, 1'b0));   // short alert
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd300, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd360, 1'b1));   // cancel
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd400, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd410, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd470, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd3470, 1'b1));  // long alert
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd3500, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd9000, 1'b0));  // armed, expiry skipped
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd9001, 1'b0));  // window expired
    send_request(make_req(pbpc_pkg::CMD_START, 32'hFFFF_FFC0, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'hFFFF_FFF0, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'h0000_0030, 1'b1)); // debounce across wrap
    send_request(make_req(pbpc_pkg::CMD_START, 32'd5, 1'b1));      // restart while pressed
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd6, 1'b0));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd7, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'd100, 1'b1));
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 1'b0)); // late release
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'h0000_0100, 1'b0)); // short alert
    send_request(make_req(pbpc_pkg::CMD_UPDATE, 32'h8000_0000, 1'b1)); // expiry on long jump
    in_valid <= 1'b0;
    wait_idle();

    // Reset values, no idling, one long output hold-off
    run_random(200, 400, 7, 60);

    // Short times, sender mostly idle
    send_idle_pct  = 73;
    recv_stall_pct = 0;
    configure(16'd3, 32'd20, 32'd40);
    run_random(200, 8, 15, 0);

    // All times zero, receiver mostly stalling
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    configure(16'd0, 32'd0, 32'd0);
    run_random(200, 3, 25, 0);

    // Largest times, both sides idling now and then
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(200, 70000, 15, 0);

    // Window shorter than the hold time, no idling, another hold-off
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(16'd5, 32'd30, 32'd25);
    run_random(200, 10, 15, 40);

    // One-tick debounce with a long window
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    configure(16'd1, 32'd8, 32'd100);
    run_random(200, 4, 15, 0);

    if (tracker.pending_events.size() != 0)
      $display("%0d results never delivered", tracker.pending_events.size());
    if (tracker.event_mismatches == 0 && tracker.pending_events.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
sv/pbpc_pkg.sv
sv/pbpc_cfg_regs.sv
sv/pbpc_fsm.sv
sv/panic_button_press_classifier.sv
bench/testbench.sv
